// File: sv/ts_pes_depacketizer_defines.svh
// Assertion macros for the transport stream PES depacketizer.
`ifndef TS_PES_DEPACKETIZER_DEFINES_SVH
`define TS_PES_DEPACKETIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge outside reset.
`define TPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TPD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TPD_ASSERT(lbl, prop, msg)
`define TPD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: sv/ts_pes_pkg.sv
// Constants and types of the transport stream PES depacketizer.
package ts_pes_pkg;

    localparam int unsigned PKT_LEN   = 188;
    localparam logic [7:0]  PKT_LEN_B = 8'(PKT_LEN);

    localparam logic [7:0]  TS_SYNC        = 8'h47;
    localparam logic [12:0] NULL_PID       = 13'h1fff;
    localparam logic [7:0]  UNIT_START_BIT = 8'h40;
    localparam logic [7:0]  ADAPT_BIT      = 8'h20;
    localparam logic [7:0]  CC_MASK        = 8'h0f;
    localparam logic [1:0]  MARKER_BITS    = 2'b10;

    localparam logic [8:0]  SKIP_PLAIN     = 9'd4;
    localparam logic [8:0]  SKIP_ADAPT     = 9'd5;
    localparam logic [8:0]  OFFSET_MAX     = 9'd511;
    localparam logic [8:0]  HDR_LEN_OFFSET = 9'd8;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_DATA    = 2'd1,
        PH_DISCARD = 2'd2
    } unit_phase_t;

endpackage

// File: sv/ts_pes_depacketizer.sv
// Transport stream PES depacketizer: packet parsing, unit checks and data output.
//
// Usage:
//   Input channel (in_valid/in_ready) moves one stream byte per request, with
//   packet_start high on the first byte of each 188-byte packet. Packets with a
//   bad sync byte or a PID other than target_pid are dropped.
//   Configuration channel (cfg_valid/cfg_ready) writes target_pid; cfg_ready is
//   always high. Write it only while the block is idle.
//   Output channel (out_valid/out_ready) carries a result only when one of
//   data_valid, unit_end, cc_error or header_error is set.
// Timing:
//   One byte is taken per cycle while the output register is empty or out_ready
//   is high. All parsing for a byte happens in the cycle it is accepted; its
//   result appears in the output register on the next cycle.
//   The single output register sets the rate under backpressure: while a result
//   waits and out_ready is low, in_ready is low and the input stalls.
// Reset:
//   rst_n clears all parser state, sets target_pid to 8191 (no stream
//   selected) and empties the output register.
`include "ts_pes_depacketizer_defines.svh"

module ts_pes_depacketizer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        packet_start,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        data_valid,
    output logic [7:0]  pes_byte,
    output logic        unit_end,
    output logic        cc_error,
    output logic        header_error
);

    logic [12:0] target_pid_reg;
    logic [7:0]  packet_pos_reg,   packet_pos_next;
    logic        selected_reg,     selected_next;
    logic [4:0]  pid_high_reg,     pid_high_next;
    logic        unit_start_reg,   unit_start_next;
    logic        adapt_reg,        adapt_next;
    logic [8:0]  payload_skip_reg, payload_skip_next;
    logic [3:0]  last_cc_reg,      last_cc_next;
    logic        cc_known_reg,     cc_known_next;
    logic [8:0]  unit_offset_reg,  unit_offset_next;
    logic [7:0]  hdr_len_reg,      hdr_len_next;
    ts_pes_pkg::unit_phase_t phase_reg, phase_next;

    logic        out_valid_reg, out_valid_next;
    logic        dv_reg, ue_reg, cce_reg, he_reg;
    logic [7:0]  byte_reg;

    logic        take;
    logic        dv, ue, cce, he;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign take      = in_valid && in_ready;

    always_comb
    begin
        logic [7:0]  pos;
        logic [12:0] pid;
        logic [3:0]  cc_in;
        logic [3:0]  cc_exp;
        logic [8:0]  off;
        logic [7:0]  hdr_len_eff;
        logic        bad;
        ts_pes_pkg::unit_phase_t phase;

        packet_pos_next   = packet_pos_reg;
        selected_next     = selected_reg;
        pid_high_next     = pid_high_reg;
        unit_start_next   = unit_start_reg;
        adapt_next        = adapt_reg;
        payload_skip_next = payload_skip_reg;
        last_cc_next      = last_cc_reg;
        cc_known_next     = cc_known_reg;
        unit_offset_next  = unit_offset_reg;
        hdr_len_next      = hdr_len_reg;
        phase_next        = phase_reg;
        dv  = 1'b0;
        ue  = 1'b0;
        cce = 1'b0;
        he  = 1'b0;

        pos         = packet_start ? 8'd0 : packet_pos_reg;
        pid         = {pid_high_reg, data_byte};
        cc_in       = data_byte[3:0] & ts_pes_pkg::CC_MASK[3:0];
        cc_exp      = last_cc_reg + 4'd1;
        off         = unit_offset_reg;
        phase       = phase_reg;
        hdr_len_eff = hdr_len_reg;
        bad         = 1'b0;

        if (take && (packet_start
                     || (packet_pos_reg != 8'd0 && packet_pos_reg < ts_pes_pkg::PKT_LEN_B)))
        begin
            packet_pos_next = pos + 8'd1;
            priority if (pos == 8'd0)
            begin
                selected_next = 1'b0;
                // drop the rest of a packet with a bad sync byte
                if (data_byte != ts_pes_pkg::TS_SYNC)
                begin
                    packet_pos_next = ts_pes_pkg::PKT_LEN_B;
                end
            end
            else if (pos == 8'd1)
            begin
                unit_start_next = (data_byte & ts_pes_pkg::UNIT_START_BIT) != 8'd0;
                pid_high_next   = data_byte[4:0];
            end
            else if (pos == 8'd2)
            begin
                selected_next = (pid == target_pid_reg)
                                && (target_pid_reg != ts_pes_pkg::NULL_PID);
            end
            else if (!selected_reg)
            begin
                // not our stream: drop the byte
            end
            else if (pos == 8'd3)
            begin
                adapt_next        = (data_byte & ts_pes_pkg::ADAPT_BIT) != 8'd0;
                payload_skip_next = adapt_next ? ts_pes_pkg::SKIP_ADAPT
                                               : ts_pes_pkg::SKIP_PLAIN;
                cc_known_next     = 1'b1;
                if (!cc_known_reg)
                begin
                    last_cc_next = cc_in;
                end
                else
                begin
                    cce          = cc_exp != cc_in;
                    last_cc_next = cc_exp;
                end
            end
            else if (pos == 8'd4 && adapt_reg)
            begin
                payload_skip_next = ts_pes_pkg::SKIP_ADAPT + {1'b0, data_byte};
            end
            else if ({1'b0, pos} >= payload_skip_reg)
            begin
                // a new unit starts at the first payload byte after a unit start
                if ({1'b0, pos} == payload_skip_reg && unit_start_reg)
                begin
                    if (unit_offset_reg != 9'd0)
                    begin
                        ue = phase_reg == ts_pes_pkg::PH_DATA;
                        he = phase_reg == ts_pes_pkg::PH_HEADER;
                    end
                    off   = 9'd0;
                    phase = ts_pes_pkg::PH_HEADER;
                end
                phase_next = phase;

                if (off == ts_pes_pkg::HDR_LEN_OFFSET)
                begin
                    hdr_len_eff = data_byte;
                end
                hdr_len_next = hdr_len_eff;

                unique case (phase)
                    ts_pes_pkg::PH_HEADER:
                    begin
                        priority if (off == 9'd0 || off == 9'd1)
                        begin
                            bad = data_byte != 8'd0;
                        end
                        else if (off == 9'd2)
                        begin
                            bad = data_byte != 8'd1;
                        end
                        else if (off == 9'd6)
                        begin
                            bad = data_byte[7:6] != ts_pes_pkg::MARKER_BITS;
                        end
                        else
                        begin
                            bad = 1'b0;
                        end
                        if (bad)
                        begin
                            he         = 1'b1;
                            phase_next = ts_pes_pkg::PH_DISCARD;
                        end
                        else if (off >= ts_pes_pkg::HDR_LEN_OFFSET
                                 && off == ts_pes_pkg::HDR_LEN_OFFSET
                                           + {1'b0, hdr_len_eff})
                        begin
                            phase_next = ts_pes_pkg::PH_DATA;
                        end
                    end
                    ts_pes_pkg::PH_DATA:
                    begin
                        dv = 1'b1;
                    end
                    default:
                    begin
                        // discard until the next unit start
                    end
                endcase

                unit_offset_next = (off < ts_pes_pkg::OFFSET_MAX) ? off + 9'd1 : off;
            end
        end

        if (take)
        begin
            out_valid_next = dv || ue || cce || he;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_pid_reg   <= ts_pes_pkg::NULL_PID;
            packet_pos_reg   <= 8'd0;
            selected_reg     <= 1'b0;
            pid_high_reg     <= 5'd0;
            unit_start_reg   <= 1'b0;
            adapt_reg        <= 1'b0;
            payload_skip_reg <= ts_pes_pkg::SKIP_PLAIN;
            last_cc_reg      <= 4'd0;
            cc_known_reg     <= 1'b0;
            unit_offset_reg  <= 9'd0;
            hdr_len_reg      <= 8'd0;
            phase_reg        <= ts_pes_pkg::PH_HEADER;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                target_pid_reg <= cfg_data;
            end
            packet_pos_reg   <= packet_pos_next;
            selected_reg     <= selected_next;
            pid_high_reg     <= pid_high_next;
            unit_start_reg   <= unit_start_next;
            adapt_reg        <= adapt_next;
            payload_skip_reg <= payload_skip_next;
            last_cc_reg      <= last_cc_next;
            cc_known_reg     <= cc_known_next;
            unit_offset_reg  <= unit_offset_next;
            hdr_len_reg      <= hdr_len_next;
            phase_reg        <= phase_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // result payload: load on each request that produces a result
    always_ff @(posedge clk)
    begin
        if (take && (dv || ue || cce || he))
        begin
            dv_reg   <= dv;
            byte_reg <= dv ? data_byte : 8'd0;
            ue_reg   <= ue;
            cce_reg  <= cce;
            he_reg   <= he;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_valid   = dv_reg;
    assign pes_byte     = byte_reg;
    assign unit_end     = ue_reg;
    assign cc_error     = cce_reg;
    assign header_error = he_reg;

    `TPD_ASSERT(a_result_nonempty,
        out_valid |-> (data_valid || unit_end || cc_error || header_error),
        "result with no flag set")
    `TPD_ASSERT(a_byte_zero_without_data,
        (out_valid && !data_valid) |-> (pes_byte == 8'd0),
        "pes_byte nonzero without data_valid")
    `TPD_ASSERT(a_cc_alone,
        (out_valid && cc_error) |-> (!data_valid && !unit_end && !header_error),
        "cc_error combined with payload flags")
    `TPD_ASSERT_NEVER(a_pos_range,
        packet_pos_reg > ts_pes_pkg::PKT_LEN_B,
        "packet position beyond packet length")

endmodule
